// ===== src/ssc_pkg.sv =====
// Shared types and constants for the sonar sentry controller.
`timescale 1ns / 1ps

package ssc_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] timestamp;
    logic        level;
  } in_item_t;

  typedef struct packed {
    logic signed [9:0]  drive_velocity;
    logic signed [15:0] drive_radius;
    logic               song_play;
    logic [1:0]         song_number;
    logic [2:0]         mode;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        near_threshold;
    logic [15:0]        far_threshold;
    logic [15:0]        track_margin;
    logic [8:0]         approach_speed;
    logic [8:0]         scan_speed;
    logic signed [15:0] search_radius;
    logic [6:0]         left_scan_samples;
    logic [6:0]         right_scan_samples;
  } cfg_t;

  typedef enum logic [4:0] {
    MODE_SEARCH = 5'b00001,
    MODE_LEFT   = 5'b00010,
    MODE_RIGHT  = 5'b00100,
    MODE_TRACK  = 5'b01000,
    MODE_LOCKED = 5'b10000
  } mode_e;

  localparam logic [1:0] OP_ECHO_EDGE   = 2'd0;
  localparam logic [1:0] OP_MOTION      = 2'd1;
  localparam logic [1:0] OP_MEASURE_END = 2'd2;

  localparam logic [2:0] REG_NEAR_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_FAR_THRESHOLD  = 3'd1;
  localparam logic [2:0] REG_TRACK_MARGIN   = 3'd2;
  localparam logic [2:0] REG_APPROACH_SPEED = 3'd3;
  localparam logic [2:0] REG_SCAN_SPEED     = 3'd4;
  localparam logic [2:0] REG_SEARCH_RADIUS  = 3'd5;
  localparam logic [2:0] REG_LEFT_SAMPLES   = 3'd6;
  localparam logic [2:0] REG_RIGHT_SAMPLES  = 3'd7;

  localparam logic [2:0] MODE_NUM_SEARCH = 3'd0;
  localparam logic [2:0] MODE_NUM_LEFT   = 3'd1;
  localparam logic [2:0] MODE_NUM_RIGHT  = 3'd2;
  localparam logic [2:0] MODE_NUM_TRACK  = 3'd3;
  localparam logic [2:0] MODE_NUM_LOCKED = 3'd4;

  localparam logic [1:0] SONG_NONE = 2'd0;
  localparam logic [1:0] SONG_SEEK = 2'd1;
  localparam logic [1:0] SONG_LOCK = 2'd2;

  localparam logic signed [15:0] RADIUS_STRAIGHT   = 16'sh8000;
  localparam logic signed [15:0] RADIUS_SPIN_LEFT  = 16'sd1;
  localparam logic signed [15:0] RADIUS_SPIN_RIGHT = -16'sd1;

  localparam logic [15:0] MIN_VALID_WIDTH = 16'd10;
  localparam logic [8:0]  SPEED_LIMIT     = 9'd500;

  localparam cfg_t CFG_RESET = '{
    near_threshold:     16'd10500,
    far_threshold:      16'd15000,
    track_margin:       16'd100,
    approach_speed:     9'd40,
    scan_speed:         9'd50,
    search_radius:      16'sd200,
    left_scan_samples:  7'd30,
    right_scan_samples: 7'd60
  };

  function automatic logic signed [9:0] sat_speed(logic [8:0] s);
    logic [8:0] lim;
    lim = (s > SPEED_LIMIT) ? SPEED_LIMIT : s;
    return signed'({1'b0, lim});
  endfunction

  function automatic logic [2:0] mode_num(mode_e m);
    logic [2:0] n;
    unique case (m)
      MODE_LEFT:   n = MODE_NUM_LEFT;
      MODE_RIGHT:  n = MODE_NUM_RIGHT;
      MODE_TRACK:  n = MODE_NUM_TRACK;
      MODE_LOCKED: n = MODE_NUM_LOCKED;
      default:     n = MODE_NUM_SEARCH;
    endcase
    return n;
  endfunction

endpackage

// ===== src/ssc_echo_timer.sv =====
// Echo width measurement from alternating rising and falling edge timestamps.
`timescale 1ns / 1ps

module ssc_echo_timer #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  edge_en_i,
  input  logic [TIMER_BITS-1:0] stamp_i,
  output logic [TIMER_BITS-1:0] echo_width_o
);

  logic                  expect_falling_q, expect_falling_d;
  logic [TIMER_BITS-1:0] start_q, start_d;
  logic [TIMER_BITS-1:0] width_q, width_d;

  always_comb begin
    expect_falling_d = expect_falling_q;
    start_d          = start_q;
    width_d          = width_q;
    if (edge_en_i) begin
      expect_falling_d = !expect_falling_q;
      if (!expect_falling_q) begin
        start_d = stamp_i;
      end else begin
        // wraps modulo the timer width
        width_d = stamp_i - start_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_falling_q <= 1'b0;
      start_q          <= '0;
      width_q          <= '0;
    end else begin
      expect_falling_q <= expect_falling_d;
      start_q          <= start_d;
      width_q          <= width_d;
    end
  end

  assign echo_width_o = width_q;

endmodule

// ===== src/ssc_sentry_fsm.sv =====
// Sentry mode machine: search, scan left and right, track and lock.
`timescale 1ns / 1ps

module ssc_sentry_fsm #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  ssc_pkg::in_item_t     item_i,
  input  logic [TIMER_BITS-1:0] echo_width_i,
  input  ssc_pkg::cfg_t         cfg_i,
  output logic                  res_valid_o,
  output ssc_pkg::out_item_t    res_o
);

  import ssc_pkg::*;

  localparam int CmpW = ((TIMER_BITS > 16) ? TIMER_BITS : 16) + 1;

  mode_e                 mode_q, mode_d;
  logic                  seek_q, seek_d;
  logic [TIMER_BITS-1:0] nearest_q, nearest_d;
  logic [6:0]            scan_q, scan_d;

  logic [CmpW-1:0]       echo_ext;
  logic [TIMER_BITS-1:0] min_w;
  logic [TIMER_BITS-1:0] nearest_sel;
  logic [CmpW-1:0]       bound;
  logic [6:0]            cnt_inc;
  logic                  lock_sel;
  logic signed [9:0]     vel_scan, vel_app;

  assign echo_ext    = CmpW'(echo_width_i);
  assign min_w       = (echo_width_i < nearest_q) ? echo_width_i : nearest_q;
  // after the right scan the bound uses the minimum that includes this sample
  assign nearest_sel = (mode_q == MODE_RIGHT) ? min_w : nearest_q;
  assign bound       = CmpW'(nearest_sel) + CmpW'(cfg_i.track_margin);
  assign cnt_inc     = scan_q + 7'd1;
  assign vel_scan    = sat_speed(cfg_i.scan_speed);
  assign vel_app     = sat_speed(cfg_i.approach_speed);

  always_comb begin
    mode_d      = mode_q;
    seek_d      = seek_q;
    nearest_d   = nearest_q;
    scan_d      = scan_q;
    lock_sel    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i && item_i.opcode == OP_MOTION) begin
      if (item_i.level && mode_q == MODE_SEARCH) begin
        mode_d = MODE_LEFT;
        seek_d = 1'b1;
      end
    end

    if (step_i && item_i.opcode == OP_MEASURE_END) begin
      res_valid_o = 1'b1;
      if (mode_q == MODE_LEFT && seek_q) begin
        // first sample seeds the running minimum if it is wider than MIN_VALID_WIDTH
        seek_d = 1'b0;
        if (echo_ext > CmpW'(MIN_VALID_WIDTH)) begin
          nearest_d = echo_width_i;
        end
        scan_d                = '0;
        res_o.drive_velocity  = vel_scan;
        res_o.drive_radius    = RADIUS_SPIN_LEFT;
        res_o.song_play       = 1'b1;
        res_o.song_number     = SONG_SEEK;
      end else begin
        unique case (mode_q)
          MODE_LEFT: begin
            nearest_d            = min_w;
            res_o.drive_velocity = vel_scan;
            if (cnt_inc >= cfg_i.left_scan_samples) begin
              scan_d             = '0;
              mode_d             = MODE_RIGHT;
              res_o.drive_radius = RADIUS_SPIN_RIGHT;
            end else begin
              scan_d             = cnt_inc;
              res_o.drive_radius = RADIUS_SPIN_LEFT;
            end
          end
          MODE_RIGHT: begin
            nearest_d = min_w;
            if (cnt_inc >= cfg_i.right_scan_samples) begin
              scan_d   = '0;
              lock_sel = 1'b1;
            end else begin
              scan_d               = cnt_inc;
              res_o.drive_velocity = vel_scan;
              res_o.drive_radius   = RADIUS_SPIN_RIGHT;
            end
          end
          MODE_TRACK: begin
            lock_sel = 1'b1;
          end
          MODE_LOCKED: begin
            res_o.drive_radius = RADIUS_STRAIGHT;
            if (echo_ext > CmpW'(cfg_i.far_threshold)) begin
              res_o.drive_velocity = vel_app;
            end else if (echo_ext < CmpW'(cfg_i.near_threshold)) begin
              res_o.drive_velocity = -vel_app;
            end else begin
              res_o.drive_velocity = '0;
            end
          end
          default: begin
            mode_d               = MODE_SEARCH;
            res_o.drive_velocity = vel_app;
            res_o.drive_radius   = cfg_i.search_radius;
          end
        endcase

        if (lock_sel) begin
          if (echo_ext > bound) begin
            mode_d               = MODE_TRACK;
            res_o.drive_velocity = vel_scan;
            res_o.drive_radius   = RADIUS_SPIN_LEFT;
          end else begin
            mode_d               = MODE_LOCKED;
            res_o.drive_velocity = '0;
            res_o.drive_radius   = RADIUS_STRAIGHT;
            res_o.song_play      = 1'b1;
            res_o.song_number    = SONG_LOCK;
          end
        end
      end
      res_o.mode = mode_num(mode_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_SEARCH;
      seek_q    <= 1'b0;
      nearest_q <= '0;
      scan_q    <= '0;
    end else begin
      mode_q    <= mode_d;
      seek_q    <= seek_d;
      nearest_q <= nearest_d;
      scan_q    <= scan_d;
    end
  end

  a_seek_in_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seek_q |-> mode_q == MODE_LEFT)
    else $error("seek pending outside scan left");

  a_song_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.song_play |-> res_o.song_number != SONG_NONE)
    else $error("song play without song number");

  a_lock_entry_song: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && mode_d == MODE_LOCKED && mode_q != MODE_LOCKED |-> res_o.song_play)
    else $error("lock entered without lock song");

endmodule

// ===== src/sonar_sentry_controller_unit.sv =====
// Top level of the sonar sentry controller: handshakes, config and pipeline registers.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o / in_item_i) carries events: echo
//    edges with a timestamp, motion sensor levels and end-of-measurement ticks.
//  - Only an end-of-measurement item produces a result item on the output
//    channel (out_valid_o / out_ready_i / out_item_o); other items update state.
//  - Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i)
//    writes the eight tuning registers; it is always ready. Write it only while
//    the block is idle.
//  - Throughput: one item per cycle while the receiver does not stall. An item is
//    registered in the input register, and its result is then loaded into the
//    output register, from which it is visible.
//  - When the receiver stalls, the result stays in the output register and the
//    input register holds the next item; in_ready_o drops only while both are full.
//  - Reset: mode search, echo polarity expects a rising edge, all widths and
//    counters zero, tuning registers at their defaults.
`timescale 1ns / 1ps

module sonar_sentry_controller_unit #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ssc_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ssc_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  import ssc_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  logic                  s1_valid_q, s1_valid_d;
  in_item_t              s1_item_q;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q;
  logic                  s1_adv;
  logic                  step;
  logic                  edge_en;
  logic [TIMER_BITS-1:0] echo_width;
  logic                  res_valid;
  out_item_t             res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NEAR_THRESHOLD: cfg_d.near_threshold     = cfg_data_i;
        REG_FAR_THRESHOLD:  cfg_d.far_threshold      = cfg_data_i;
        REG_TRACK_MARGIN:   cfg_d.track_margin       = cfg_data_i;
        REG_APPROACH_SPEED: cfg_d.approach_speed     = cfg_data_i[8:0];
        REG_SCAN_SPEED:     cfg_d.scan_speed         = cfg_data_i[8:0];
        REG_SEARCH_RADIUS:  cfg_d.search_radius      = signed'(cfg_data_i);
        REG_LEFT_SAMPLES:   cfg_d.left_scan_samples  = cfg_data_i[6:0];
        REG_RIGHT_SAMPLES:  cfg_d.right_scan_samples = cfg_data_i[6:0];
      endcase
    end
  end

  // stage 1 moves whenever the output slot is free or being drained
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign step       = s1_valid_q && s1_adv;
  assign edge_en    = step && s1_item_q.opcode == OP_ECHO_EDGE;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = (out_valid_q && !out_ready_i) || (step && res_valid);
  end

  ssc_echo_timer #(
    .TIMER_BITS(TIMER_BITS)
  ) u_echo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .edge_en_i    (edge_en),
    .stamp_i      (TIMER_BITS'(s1_item_q.timestamp)),
    .echo_width_o (echo_width)
  );

  ssc_sentry_fsm #(
    .TIMER_BITS(TIMER_BITS)
  ) u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (s1_item_q),
    .echo_width_i (echo_width),
    .cfg_i        (cfg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
    if (step && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item not in input register");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled item lost from input register");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && s1_item_q.opcode == OP_MEASURE_END |=> out_valid_q)
    else $error("measurement end did not produce a result");

endmodule

// ===== tb/tb_sonar_sentry_controller_unit.sv =====
// Testbench for the sonar sentry controller: random event streams checked against a predictor.
`timescale 1ns / 1ps

module tb_sonar_sentry_controller_unit;
  import ssc_pkg::*;

  localparam int          CLK_PERIOD     = 10;
  localparam int          ITEM_TARGET    = 1800;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          TAIL_CYCLES    = 8;
  localparam int          SQUEEZE_CYCLES = 80;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          SPEED_CAP      = 500;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;

  // Tracks the sentry state and config, queues the command each tick should produce.
  class sentry_scoreboard;
    cfg_t        cfg;
    logic [2:0]  mode;
    bit          seek_pending;
    bit          expect_falling;
    logic [15:0] echo_start;
    logic [15:0] echo_width;
    logic [15:0] nearest_width;
    logic [6:0]  scan_count;
    out_item_t   expected_q[$];
    int          mismatches;

    function new();
      cfg            = CFG_RESET;
      mode           = MODE_NUM_SEARCH;
      seek_pending   = 1'b0;
      expect_falling = 1'b0;
      echo_start     = '0;
      echo_width     = '0;
      nearest_width  = '0;
      scan_count     = '0;
      mismatches     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_config(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_NEAR_THRESHOLD: cfg.near_threshold = data;
        REG_FAR_THRESHOLD:  cfg.far_threshold = data;
        REG_TRACK_MARGIN:   cfg.track_margin = data;
        REG_APPROACH_SPEED: cfg.approach_speed = data[8:0];
        REG_SCAN_SPEED:     cfg.scan_speed = data[8:0];
        REG_SEARCH_RADIUS:  cfg.search_radius = data;
        REG_LEFT_SAMPLES:   cfg.left_scan_samples = data[6:0];
        REG_RIGHT_SAMPLES:  cfg.right_scan_samples = data[6:0];
        default: ;
      endcase
    endfunction

    function logic signed [9:0] speed_cmd(logic [8:0] s);
      return (s > SPEED_CAP) ? 10'(SPEED_CAP) : 10'(s);
    endfunction

    function out_item_t cmd(logic signed [9:0] vel, logic signed [15:0] rad, logic play,
                            logic [1:0] song);
      out_item_t r;
      r.drive_velocity = vel;
      r.drive_radius   = rad;
      r.song_play      = play;
      r.song_number    = song;
      r.mode           = mode;
      return r;
    endfunction

    function bit sample_counted(logic [6:0] limit);
      scan_count = scan_count + 7'd1;
      return scan_count >= limit;
    endfunction

    // bound is one bit wider so a large margin never wraps
    function out_item_t aim_or_lock();
      logic [16:0] bound;
      bound = {1'b0, nearest_width} + {1'b0, cfg.track_margin};
      if ({1'b0, echo_width} > bound) begin
        mode = MODE_NUM_TRACK;
        return cmd(speed_cmd(cfg.scan_speed), RADIUS_SPIN_LEFT, 1'b0, SONG_NONE);
      end
      mode = MODE_NUM_LOCKED;
      return cmd(10'sd0, RADIUS_STRAIGHT, 1'b1, SONG_LOCK);
    endfunction

    function out_item_t measure_end();
      logic signed [9:0] spin;
      logic signed [9:0] keep;
      spin = speed_cmd(cfg.scan_speed);
      keep = speed_cmd(cfg.approach_speed);
      if (mode == MODE_NUM_LEFT && seek_pending) begin
        seek_pending = 1'b0;
        if (echo_width > MIN_VALID_WIDTH) nearest_width = echo_width;
        scan_count = '0;
        return cmd(spin, RADIUS_SPIN_LEFT, 1'b1, SONG_SEEK);
      end
      if ((mode == MODE_NUM_LEFT || mode == MODE_NUM_RIGHT) && echo_width < nearest_width)
        nearest_width = echo_width;
      case (mode)
        MODE_NUM_LEFT: begin
          if (!sample_counted(cfg.left_scan_samples))
            return cmd(spin, RADIUS_SPIN_LEFT, 1'b0, SONG_NONE);
          scan_count = '0;
          mode = MODE_NUM_RIGHT;
          return cmd(spin, RADIUS_SPIN_RIGHT, 1'b0, SONG_NONE);
        end
        MODE_NUM_RIGHT: begin
          if (!sample_counted(cfg.right_scan_samples))
            return cmd(spin, RADIUS_SPIN_RIGHT, 1'b0, SONG_NONE);
          scan_count = '0;
          return aim_or_lock();
        end
        MODE_NUM_TRACK: return aim_or_lock();
        MODE_NUM_LOCKED: begin
          if (echo_width > cfg.far_threshold)
            return cmd(keep, RADIUS_STRAIGHT, 1'b0, SONG_NONE);
          if (echo_width < cfg.near_threshold)
            return cmd(-keep, RADIUS_STRAIGHT, 1'b0, SONG_NONE);
          return cmd(10'sd0, RADIUS_STRAIGHT, 1'b0, SONG_NONE);
        end
        default: begin
          mode = MODE_NUM_SEARCH;
          return cmd(keep, cfg.search_radius, 1'b0, SONG_NONE);
        end
      endcase
    endfunction

    function void note_input(in_item_t it);
      case (it.opcode)
        OP_ECHO_EDGE: begin
          if (!expect_falling) begin
            echo_start     = it.timestamp;
            expect_falling = 1'b1;
          end else begin
            echo_width     = it.timestamp - echo_start;
            expect_falling = 1'b0;
          end
        end
        OP_MOTION: begin
          if (it.level && mode == MODE_NUM_SEARCH) begin
            mode         = MODE_NUM_LEFT;
            seek_pending = 1'b1;
          end
        end
        OP_MEASURE_END: expected_q.push_back(measure_end());
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: vel %0d rad %0d play %0b song %0d mode %0d",
                   $time, got.drive_velocity, got.drive_radius, got.song_play,
                   got.song_number, got.mode);
        return;
      end
      want = expected_q.pop_front();
      if (got.drive_velocity !== want.drive_velocity || got.drive_radius !== want.drive_radius ||
          got.song_play !== want.song_play || got.song_number !== want.song_number ||
          got.mode !== want.mode) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: bad result, expected vel %0d rad %0d play %0b song %0d mode %0d",
                   $time, want.drive_velocity, want.drive_radius, want.song_play,
                   want.song_number, want.mode);
          $display("%0t:             got      vel %0d rad %0d play %0b song %0d mode %0d",
                   $time, got.drive_velocity, got.drive_radius, got.song_play,
                   got.song_number, got.mode);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  sentry_scoreboard sb;
  int items_sent = 0;
  int gap_pct = 0;
  int quiet = 0;
  bit calm = 1'b0;
  bit squeeze_req = 1'b0;
  bit stall_mode = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sonar_sentry_controller_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // ---------------- sender side ----------------

  task automatic pace();
    if (!calm && !squeeze_req && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic send_event(in_item_t it);
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    items_sent++;
    pace();
  endtask

  task automatic send_op(logic [1:0] op, logic [15:0] ts, logic lvl);
    in_item_t it;
    it.opcode    = op;
    it.timestamp = ts;
    it.level     = lvl;
    send_event(it);
  endtask

  task automatic send_edge(logic [15:0] ts);
    send_op(OP_ECHO_EDGE, ts, 1'($urandom));
  endtask

  task automatic send_motion(logic lvl);
    send_op(OP_MOTION, 16'($urandom), lvl);
  endtask

  task automatic send_tick();
    send_op(OP_MEASURE_END, 16'($urandom), 1'($urandom));
  endtask

  task automatic send_noise(bit motion_ok);
    case ($urandom_range(0, 3))
      0: send_edge(16'($urandom));
      1: send_motion(motion_ok ? 1'($urandom) : 1'b0);
      2: send_op(OP_UNUSED, 16'($urandom), 1'($urandom));
      default: send_motion(1'b0);
    endcase
  endtask

  // rising/falling pair then a tick; a stray edge first if polarity is off
  task automatic measure_width(logic [15:0] w);
    logic [15:0] t;
    t = 16'($urandom);
    if (sb.expect_falling) send_edge(16'($urandom));
    send_edge(t);
    send_edge(t + w);
    send_tick();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
  endtask

  // field all zeros, all ones or random; bits above the field are junk
  function automatic logic [15:0] spread_value(int bits);
    logic [15:0] m;
    logic [15:0] v;
    m = 16'((32'd1 << bits) - 1);
    v = 16'($urandom);
    case ($urandom_range(0, 3))
      0: v = v & ~m;
      1: v = v | m;
      default: ;
    endcase
    return v;
  endfunction

  task automatic write_all();
    write_reg(REG_NEAR_THRESHOLD, spread_value(16));
    write_reg(REG_FAR_THRESHOLD, spread_value(16));
    write_reg(REG_TRACK_MARGIN, spread_value(16));
    write_reg(REG_APPROACH_SPEED, spread_value(9));
    write_reg(REG_SCAN_SPEED, spread_value(9));
    write_reg(REG_SEARCH_RADIUS, spread_value(16));
    write_reg(REG_LEFT_SAMPLES, spread_value(7));
    write_reg(REG_RIGHT_SAMPLES, spread_value(7));
  endtask

  function automatic logic [15:0] scan_width();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 12));
      1: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] lock_width();
    case ($urandom_range(0, 5))
      0: return sb.cfg.near_threshold - 16'd1;
      1: return sb.cfg.near_threshold;
      2: return sb.cfg.far_threshold;
      3: return sb.cfg.far_threshold + 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int          phase_end;
    int          span;
    int          k;
    logic [16:0] bound;
    logic [15:0] dir_speed[3];
    logic [15:0] dir_radius[3];

    sb = new();
    dir_speed  = '{16'h01FF, 16'd500, 16'hFE00};
    dir_radius = '{16'h8000, 16'h7FFF, 16'hFFFF};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, timestamp wrap both ways, ignored items
    send_tick();
    send_edge(16'hFFFF);
    send_edge(16'h0000);
    send_tick();
    send_edge(16'h0000);
    send_edge(16'hFFFF);
    send_tick();
    send_motion(1'b0);
    send_op(OP_UNUSED, 16'hFFFF, 1'b1);
    send_tick();
    // speed saturation and radius extremes while circling
    for (int i = 0; i < 3; i++) begin
      drain();
      write_reg(REG_APPROACH_SPEED, dir_speed[i]);
      write_reg(REG_SEARCH_RADIUS, dir_radius[i]);
      end_writes();
      send_tick();
      send_tick();
    end

    // search: motion stays low so the machine keeps circling
    for (int p = 0; p < 4; p++) begin
      drain();
      write_all();
      end_writes();
      gap_pct   = pick_gap();
      phase_end = items_sent + 110;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: measure_width(scan_width());
          4, 5, 6:    send_tick();
          default:    send_noise(1'b0);
        endcase
      end
    end

    // seek and scan
    drain();
    write_reg(REG_SCAN_SPEED, spread_value(9));
    write_reg(REG_LEFT_SAMPLES, spread_value(7));
    write_reg(REG_RIGHT_SAMPLES, spread_value(7));
    write_reg(REG_TRACK_MARGIN, 16'($urandom_range(0, 300)));
    end_writes();
    gap_pct = pick_gap();
    send_edge(16'($urandom));
    send_motion(1'b1);
    if ($urandom_range(0, 1) == 0) measure_width(16'($urandom_range(0, 10)));
    else measure_width(16'($urandom_range(11, 65535)));
    while (sb.mode == MODE_NUM_LEFT || sb.mode == MODE_NUM_RIGHT) begin
      if ($urandom_range(0, 6) == 0) send_noise(1'b1);
      else measure_width(scan_width());
    end

    // turn toward the target; margin rewritten at iteration 120
    k = 0;
    while (sb.mode == MODE_NUM_TRACK && k < 300) begin
      if (k == 120) begin
        drain();
        write_reg(REG_TRACK_MARGIN, spread_value(16));
        end_writes();
      end
      bound = {1'b0, sb.nearest_width} + {1'b0, sb.cfg.track_margin};
      case ($urandom_range(0, 39))
        0:          measure_width(bound[16] ? 16'hFFFF : bound[15:0]);
        1:          measure_width(bound[15:0] + 16'd1);
        2, 3, 4, 5: send_noise(1'b1);
        default:    measure_width(16'($urandom));
      endcase
      k++;
    end
    if (sb.mode == MODE_NUM_TRACK) measure_width(16'd0);

    // locked: distance keeping under several threshold settings
    for (int q = 0; q < 6; q++) begin
      drain();
      write_all();
      if (q == 0) begin
        write_reg(REG_NEAR_THRESHOLD, 16'h0000);
        write_reg(REG_FAR_THRESHOLD, 16'hFFFF);
      end else if (q == 1) begin
        write_reg(REG_NEAR_THRESHOLD, 16'hFFFF);
        write_reg(REG_FAR_THRESHOLD, 16'h0000);
      end
      end_writes();
      gap_pct = pick_gap();
      if (q == 2) squeeze_req = 1'b1;
      if (q == 5) calm = 1'b1;
      span = (ITEM_TARGET - items_sent) / (6 - q);
      if (span < 40) span = 40;
      phase_end = items_sent + span;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: measure_width(lock_width());
          7:                   send_tick();
          default:             send_noise(1'b1);
        endcase
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("sonar_sentry_controller_unit: match");
    else
      $display("sonar_sentry_controller_unit: mismatch");
    $finish;
  end

  // ---------------- receiver side ----------------

  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) == 0) stall_mode = !stall_mode;
      if (squeeze_req) begin
        // long hold-off so the block fills and backs up the input
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && stall_mode && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= WATCHDOG_LIMIT);
    $display("sonar_sentry_controller_unit: mismatch");
    $finish;
  end

endmodule
